FILE: design/sst_pkg.sv
// Shared types, codes and command/status structs for the slot set table.
package sst_pkg;

    localparam int CMD_W     = 3;
    localparam int KEY_IN_W  = 32;
    localparam int RANK_W    = 6;
    localparam int STATUS_W  = 2;
    localparam int KEY_OUT_W = 32;
    localparam int FILLED_W  = 7;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EXISTS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_KEY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [KEY_IN_W-1:0] key;
        logic [RANK_W-1:0]   rank;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 found;
        logic [KEY_OUT_W-1:0] key_out;
        logic [FILLED_W-1:0]  filled_count;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic sweep;
        logic scan;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic op_scan;
        logic op_sweep;
        logic sweep_last;
        logic scan_stop;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: design/sst_dp.sv
// Datapath: slot memory, scan pipeline, fill count and result register.
module sst_dp #(
    parameter int SLOTS    = 64,
    parameter int KEY_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sst_pkg::dp_cmd_t cmd,
    output sst_pkg::dp_stat_t stat,
    input  sst_pkg::req_t    req,
    output sst_pkg::rsp_t    rsp,
    output logic             rsp_valid,
    input  logic             rsp_ready
);
    import sst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = (CW > RANK_W) ? CW : RANK_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    logic [KEY_BITS-1:0] mem [SLOTS];
    logic [KEY_BITS-1:0] rd_data_reg;

    logic [CMD_W-1:0]     op_reg, op_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [RANK_W-1:0]    rank_reg, rank_next;
    logic [IW-1:0]        addr_reg, addr_next;
    logic                 issue_reg, issue_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [IW-1:0]        chk_idx_reg, chk_idx_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [SW-1:0]        seen_reg, seen_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 found_reg, found_next;
    logic [KEY_OUT_W-1:0] key_out_reg, key_out_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic [KEY_BITS-1:0] key_in;
    logic                zero_rd;
    logic                key_eq;
    logic                rank_eq;
    logic                chk_last;
    logic                hit;
    logic                key_zero;
    logic                we;
    logic [IW-1:0]       waddr;
    logic [KEY_BITS-1:0] wdata;
    logic                re;

    assign key_in   = KEY_BITS'(req.key);
    assign zero_rd  = (rd_data_reg == '0);
    assign key_eq   = (rd_data_reg == key_reg);
    assign rank_eq  = (seen_reg == SW'(rank_reg));
    assign chk_last = (chk_idx_reg == LAST_IDX);
    assign key_zero = (key_reg == '0);

    always_comb
    begin
        unique case (op_reg)
            CMD_ADD:    hit = zero_rd;
            CMD_REMOVE: hit = key_eq;
            CMD_EXISTS: hit = key_eq;
            CMD_GET:    hit = !zero_rd && rank_eq;
            default:    hit = 1'b0;
        endcase
    end

    assign stat.scan_stop  = chk_valid_reg && ((hit && op_reg != CMD_REMOVE) || chk_last);
    assign stat.sweep_last = (addr_reg == LAST_IDX);
    assign stat.op_sweep   = (op_reg == CMD_CLEAR);
    assign stat.op_scan    = ((op_reg == CMD_ADD || op_reg == CMD_REMOVE) && !key_zero)
                             || op_reg == CMD_EXISTS || op_reg == CMD_GET;
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

    assign re = cmd.scan && issue_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = addr_reg;
        wdata = '0;
        priority if (cmd.sweep)
        begin
            we = 1'b1;
        end
        else if (cmd.scan && chk_valid_reg && hit
                 && (op_reg == CMD_ADD || op_reg == CMD_REMOVE))
        begin
            we    = 1'b1;
            waddr = chk_idx_reg;
            wdata = (op_reg == CMD_ADD) ? key_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        rank_next      = rank_reg;
        addr_next      = addr_reg;
        issue_next     = issue_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        count_next     = count_reg;
        seen_next      = seen_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        key_out_next   = key_out_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (cmd.load)
        begin
            op_next        = req.command;
            key_next       = key_in;
            rank_next      = req.rank;
            addr_next      = '0;
            issue_next     = 1'b1;
            chk_valid_next = 1'b0;
            seen_next      = '0;
            found_next     = 1'b0;
            key_out_next   = '0;
            status_next    = ((req.command == CMD_ADD || req.command == CMD_REMOVE)
                              && key_in == '0) ? ST_ZERO_KEY : ST_DONE;
        end

        if (cmd.sweep)
        begin
            addr_next = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
            if (addr_reg == LAST_IDX)
            begin
                count_next = '0;
            end
        end

        if (cmd.scan)
        begin
            if (issue_reg)
            begin
                chk_valid_next = 1'b1;
                chk_idx_next   = addr_reg;
                if (addr_reg == LAST_IDX)
                begin
                    issue_next = 1'b0;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            else
            begin
                chk_valid_next = 1'b0;
            end

            if (chk_valid_reg)
            begin
                if (hit)
                begin
                    unique case (op_reg)
                        CMD_ADD:    count_next = count_reg + 1'b1;
                        CMD_REMOVE:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_EXISTS: found_next = 1'b1;
                        CMD_GET:
                        begin
                            found_next   = 1'b1;
                            key_out_next = KEY_OUT_W'(rd_data_reg);
                        end
                        default:    found_next = found_reg;
                    endcase
                end
                else
                begin
                    if (op_reg == CMD_GET && !zero_rd)
                    begin
                        seen_next = seen_reg + 1'b1;
                    end
                    if (op_reg == CMD_ADD && chk_last)
                    begin
                        status_next = ST_FULL;
                    end
                end
            end
        end

        if (cmd.emit)
        begin
            rsp_next.status       = status_reg;
            rsp_next.found        = found_reg;
            rsp_next.key_out      = key_out_reg;
            rsp_next.filled_count = FILLED_W'(count_reg);
            rsp_valid_next        = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            issue_reg     <= 1'b0;
            chk_valid_reg <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            addr_reg      <= addr_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        rank_reg    <= rank_next;
        chk_idx_reg <= chk_idx_next;
        seen_reg    <= seen_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        key_out_reg <= key_out_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

FILE: design/sst_ctrl.sv
// Controller: sequences reset sweep, request decode, scan or sweep, and result hand-off.
module sst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sst_pkg::dp_stat_t stat,
    output sst_pkg::dp_cmd_t  cmd
);
    import sst_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_SWEEP,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
                if (req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (stat.op_sweep)
                begin
                    state_next = S_SWEEP;
                end
                else if (stat.op_scan)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_stop)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/slot_set_table_top.sv
// Top level of the slot set table: controller, datapath and checks.
//
// Requests arrive on req (command, key, rank) under req_valid/req_ready;
// one result per request leaves on rsp (status, found, key_out,
// filled_count) under rsp_valid/rsp_ready.
// Scanning and clearing requests walk the slot memory one slot per cycle, so
// the memory read port sets the rate:
//   add, remove, exists, get: scan the slots in order;
//     add, exists and get stop at the first hit.
//   clear: writes every slot to zero.
//   zero-key add or remove, unused codes: no memory access.
// req_ready is high only between requests. It rises again in the cycle
// after a result is issued. A finished result sits in the output register;
// the next request is accepted while it waits, and that request's result
// holds in the datapath until the register frees.
// After reset a clearing pass writes every slot to zero with req_ready
// low; the fill count resets to zero.
// A stalled rsp_ready holds rsp and rsp_valid unchanged.
module slot_set_table_top #(
    parameter int SLOTS    = 64,
    parameter int KEY_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  sst_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output sst_pkg::rsp_t rsp
);
    import sst_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sst_dp #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (int'(rsp.filled_count) <= SLOTS))
        else $error("fill count above table size");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.filled_count == FILLED_W'(SLOTS))
        else $error("full reported with free slots");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> rsp.status == ST_DONE)
        else $error("found with non-done status");

    a_key_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.key_out != '0 |-> rsp.found)
        else $error("key returned without found");

endmodule
